### src/acc_pkg.sv
// ----------------------------------------------------------------------------
// Accumulator core package
// Shared types, codes and constants of the accumulator core.
// ----------------------------------------------------------------------------
package acc_pkg;

	localparam int MemWords = 1024;
	localparam int AddrW = $clog2(MemWords);
	localparam int WordW = 32;
	localparam logic [AddrW-1:0] DataFirst = AddrW'(MemWords / 2);

	typedef enum logic [1:0] {
		ACT_WR_INSTR = 2'd0,
		ACT_WR_DATA  = 2'd1,
		ACT_RD_DATA  = 2'd2,
		ACT_STEP     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_ADDR = 3'd1,
		ST_HALTED   = 3'd2,
		ST_SKIPPED  = 3'd3,
		ST_DIV_ZERO = 3'd4
	} status_t;

	localparam logic [5:0] OP_LOAD    = 6'd1;
	localparam logic [5:0] OP_ADD     = 6'd5;
	localparam logic [5:0] OP_SUB     = 6'd6;
	localparam logic [5:0] OP_LOAD_MX = 6'd9;
	localparam logic [5:0] OP_LOAD_MQ = 6'd10;
	localparam logic [5:0] OP_MUL     = 6'd11;
	localparam logic [5:0] OP_DIV     = 6'd12;
	localparam logic [5:0] OP_STOR    = 6'd33;

	typedef enum logic [2:0] {
		S_IDLE, S_CLEAR, S_FETCH, S_DECODE, S_OPER, S_ITER, S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [AddrW-1:0] mem_address;
		logic signed [WordW-1:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic signed [WordW-1:0] read_value;
		logic signed [WordW-1:0] accumulator;
		logic signed [WordW-1:0] quotient_reg;
		logic [AddrW-1:0] program_counter;
	} out_item_t;

endpackage

### src/accumulator_cpu_core.sv
// ----------------------------------------------------------------------------
// Accumulator CPU core
// Accumulator machine with AC, MQ, PC and a 1024-word memory.
// ----------------------------------------------------------------------------
// After reset the core clears its memory one word a cycle and takes no item
// meanwhile. Memory writes and reads pass FETCH and DONE, a plain step passes
// FETCH, DECODE, OPER and DONE, and MUL and a DIV by nonzero add ITER, where
// one shared 33-bit adder does one bit of the product or quotient per cycle.
// The result sits in an output register; the next item is taken once it is transferred.
module accumulator_cpu_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  acc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output acc_pkg::out_item_t out_data
);

	localparam int AW = acc_pkg::AddrW;
	localparam int W = acc_pkg::WordW;

	acc_pkg::state_t state_q, state_d;
	logic [W-1:0] mem [acc_pkg::MemWords];
	logic [W-1:0] rdata_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] pc_q;
	logic [W-1:0] ac_q, mq_q, ir_q, m_q, rd_q;
	logic [W-1:0] rem_q, dvs_q;
	logic [5:0] cnt_q;
	logic [2:0] st_q;
	logic [1:0] act_q;
	logic [AW-1:0] addr_q;
	logic [W-1:0] wval_q;
	logic neg_q_q, neg_r_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [W-1:0] wdata;

	logic [5:0] op;
	logic [AW-1:0] opnd;
	assign op = ir_q[5:0];
	assign opnd = ir_q[15:6];

	// Shared adder: MUL adds the multiplicand to the doubled partial product,
	// DIV trial-subtracts the divisor.
	logic [W:0] sum;
	logic [W-1:0] rem_sh;
	assign rem_sh = {rem_q[W-2:0], mq_q[W-1]};
	assign sum = (op == acc_pkg::OP_MUL) ? {1'b0, rem_q[W-2:0], 1'b0} + {1'b0, dvs_q}
		: {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= acc_pkg::S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		we = 1'b0;
		waddr = addr_q;
		wdata = wval_q;
		raddr = addr_q;
		case (state_q)
			acc_pkg::S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (&clr_q) state_d = acc_pkg::S_IDLE;
			end
			acc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = acc_pkg::S_FETCH;
			end
			acc_pkg::S_FETCH: begin
				raddr = (act_q == acc_pkg::ACT_STEP) ? pc_q : addr_q;
				if (act_q == acc_pkg::ACT_STEP && pc_q < acc_pkg::DataFirst)
					state_d = acc_pkg::S_DECODE;
				else state_d = acc_pkg::S_DONE;
				if (act_q == acc_pkg::ACT_WR_INSTR && addr_q < acc_pkg::DataFirst) we = 1'b1;
				if (act_q == acc_pkg::ACT_WR_DATA && addr_q >= acc_pkg::DataFirst) we = 1'b1;
			end
			acc_pkg::S_DECODE: begin
				raddr = rdata_q[15:6];
				state_d = acc_pkg::S_OPER;
			end
			acc_pkg::S_OPER: begin
				state_d = acc_pkg::S_DONE;
				if (st_q == acc_pkg::ST_OK) begin
					if (op == acc_pkg::OP_STOR) begin
						we = 1'b1;
						waddr = opnd;
						wdata = ac_q;
					end
					if ((op == acc_pkg::OP_MUL) || (op == acc_pkg::OP_DIV && rdata_q != '0))
						state_d = acc_pkg::S_ITER;
				end
			end
			acc_pkg::S_ITER: if (cnt_q == 6'(W - 1)) state_d = acc_pkg::S_DONE;
			acc_pkg::S_DONE: begin
				raddr = addr_q;
				if (out_valid && out_ready) state_d = acc_pkg::S_IDLE;
			end
			default: state_d = acc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			pc_q <= '0;
			ac_q <= '0;
			mq_q <= '0;
			ir_q <= '0;
			out_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				acc_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
				acc_pkg::S_IDLE: if (in_valid) begin
					act_q <= in_data.action;
					addr_q <= in_data.mem_address;
					wval_q <= in_data.write_value;
					st_q <= acc_pkg::ST_OK;
					rd_q <= '0;
				end
				acc_pkg::S_FETCH: begin
					case (act_q)
						acc_pkg::ACT_WR_INSTR:
							if (addr_q >= acc_pkg::DataFirst) st_q <= acc_pkg::ST_BAD_ADDR;
						acc_pkg::ACT_WR_DATA, acc_pkg::ACT_RD_DATA:
							if (addr_q < acc_pkg::DataFirst) st_q <= acc_pkg::ST_BAD_ADDR;
						default:
							if (pc_q >= acc_pkg::DataFirst) st_q <= acc_pkg::ST_HALTED;
							else pc_q <= pc_q + 1'b1;
					endcase
				end
				acc_pkg::S_DECODE: begin
					ir_q <= rdata_q;
					if (rdata_q[15:6] != '0 && rdata_q[15:6] < acc_pkg::DataFirst)
						st_q <= acc_pkg::ST_SKIPPED;
				end
				acc_pkg::S_OPER: if (st_q == acc_pkg::ST_OK) begin
					cnt_q <= '0;
					case (op)
						acc_pkg::OP_LOAD_MQ: ac_q <= mq_q;
						acc_pkg::OP_LOAD_MX: mq_q <= rdata_q;
						acc_pkg::OP_LOAD: ac_q <= rdata_q;
						acc_pkg::OP_ADD: ac_q <= ac_q + rdata_q;
						acc_pkg::OP_SUB: ac_q <= ac_q - rdata_q;
						acc_pkg::OP_MUL: begin
							// Product low half builds in rem_q, multiplier shifts out of mq_q.
							dvs_q <= rdata_q;
							rem_q <= '0;
						end
						acc_pkg::OP_DIV: begin
							if (rdata_q == '0) st_q <= acc_pkg::ST_DIV_ZERO;
							else begin
								dvs_q <= rdata_q[W-1] ? -rdata_q : rdata_q;
								mq_q <= ac_q[W-1] ? -ac_q : ac_q;
								rem_q <= '0;
								neg_q_q <= ac_q[W-1] ^ rdata_q[W-1];
								neg_r_q <= ac_q[W-1];
							end
						end
						default: ;
					endcase
				end
				acc_pkg::S_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (op == acc_pkg::OP_MUL) begin
						// Shift-add from the multiplier's top bit; mod 2^32 only.
						if (cnt_q == 6'(W - 1)) begin
							mq_q <= mq_q[W-1] ? sum[W-1:0] : {rem_q[W-2:0], 1'b0};
							ac_q <= '0;
						end else begin
							rem_q <= mq_q[W-1] ? sum[W-1:0] : {rem_q[W-2:0], 1'b0};
							mq_q <= {mq_q[W-2:0], 1'b0};
						end
					end else begin
						logic [W-1:0] r_n, q_n;
						r_n = sum[W] ? rem_sh : sum[W-1:0];
						q_n = {mq_q[W-2:0], ~sum[W]};
						rem_q <= r_n;
						if (cnt_q == 6'(W - 1)) begin
							mq_q <= neg_q_q ? -q_n : q_n;
							ac_q <= neg_r_q ? -r_n : r_n;
						end else mq_q <= q_n;
					end
				end
				default: ;
			endcase
			if (state_q == acc_pkg::S_DONE && !out_valid && state_d == acc_pkg::S_DONE) begin
				out_valid <= 1'b1;
				out_data.status <= st_q;
				out_data.read_value <= (act_q == acc_pkg::ACT_RD_DATA)
					? ((st_q == acc_pkg::ST_OK) ? rdata_q : '1) : rd_q;
				out_data.accumulator <= ac_q;
				out_data.quotient_reg <= mq_q;
				out_data.program_counter <= pc_q;
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == acc_pkg::S_IDLE) else $error("ready outside idle");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= acc_pkg::DataFirst) else $error("pc out of range");

endmodule
